>>> design/rstp_pkg.sv
package rstp_pkg;

   localparam int RANGE_BITS    = 16;
   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int MAX_BEAMS     = 1024;

   localparam int REG_W      = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int GUARD      = 14;
   localparam int TURN_W     = 32;
   localparam int TABLE_LEN  = 24;
   localparam int STAGE_W    = $clog2(TABLE_LEN);
   localparam int XY_W       = RANGE_BITS + GUARD + 2;
   localparam int PROD_W     = RANGE_BITS + TURN_W;
   localparam int CNT_W      = $clog2(MAX_BEAMS + 1);
   localparam int KEPT_W     = 11;
   localparam int COORD_W    = 17;
   localparam int COORD_MAX  = 65535;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 48;

   localparam logic [TURN_W-1:0] GAIN_Q32 = 32'd2608131496;

   localparam logic [TURN_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_START_ANGLE  = 2'd0,
      CSR_ANGLE_STEP   = 2'd1,
      CSR_USABLE_RANGE = 2'd2,
      CSR_SENSOR_MAX   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              keep;
      logic [KEPT_W-1:0] kept;
      logic              last;
   } rstp_side_type;

   typedef struct packed {
      logic signed [XY_W-1:0]   x;
      logic signed [XY_W-1:0]   y;
      logic signed [TURN_W-1:0] z;
      rstp_side_type            side;
   } rstp_vec_type;

endpackage

>>> design/range_scan_to_points.sv
// Channel  Direction  Payload
// req      in         tdata[15:0] beam_range, tlast last_in_scan
// rsp      out        tdata point_x, point_y, points_kept; tuser point_valid; tlast scan_done
// csr      in         csr_addr selects the register, csr_wdata its value
//
// One beam is accepted per cycle while req_tready is high; a result passes through the front stage,
// one cell per CORDIC rotation and the output register before it reaches rsp.
// Each stage has its own valid bit, so a stall on rsp fills empty stages before req stalls.
// Synchronous reset clears all valid bits, the angle, the count, start angle and angle step.
module range_scan_to_points (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // beam_range[15:0]
   input  logic [rstp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // point_x[16:0], point_y[33:17], points_kept[44:34], zero fill[47:45]
   output logic [rstp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // point_valid
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [rstp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rstp_pkg::REG_W-1:0]      csr_wdata
);
   import rstp_pkg::*;

   logic         chain_valid [CORDIC_STAGES+1];
   logic         chain_ready [CORDIC_STAGES+1];
   rstp_vec_type chain_vec   [CORDIC_STAGES+1];

   logic                    rsp_valid_ff, rsp_valid_in, out_take;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_last_ff;
   logic signed [XY_W:0]    x_sum, y_sum, x_rnd, y_rnd;
   logic [COORD_W-1:0]      x_out, y_out;
   rstp_vec_type            tail;

   rstp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .out_valid  (chain_valid[0]),
      .out_ready  (chain_ready[0]),
      .out_vec    (chain_vec[0])
   );

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      rstp_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (STAGE_W'(g)),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_vec    (chain_vec[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_vec   (chain_vec[g+1])
      );
   end

   assign tail                       = chain_vec[CORDIC_STAGES];
   assign chain_ready[CORDIC_STAGES] = !rsp_valid_ff || rsp_tready;
   assign out_take = chain_valid[CORDIC_STAGES] && chain_ready[CORDIC_STAGES];

   always_comb begin
      x_sum = (XY_W+1)'(tail.x) + (XY_W+1)'(1 << (GUARD - 1));
      y_sum = (XY_W+1)'(tail.y) + (XY_W+1)'(1 << (GUARD - 1));
      x_rnd = x_sum >>> GUARD;
      y_rnd = y_sum >>> GUARD;
      if (x_rnd > (XY_W+1)'(COORD_MAX)) begin
         x_out = COORD_W'(COORD_MAX);
      end else if (x_rnd < -(XY_W+1)'(COORD_MAX)) begin
         x_out = COORD_W'(-COORD_MAX);
      end else begin
         x_out = COORD_W'(x_rnd);
      end
      if (y_rnd > (XY_W+1)'(COORD_MAX)) begin
         y_out = COORD_W'(COORD_MAX);
      end else if (y_rnd < -(XY_W+1)'(COORD_MAX)) begin
         y_out = COORD_W'(-COORD_MAX);
      end else begin
         y_out = COORD_W'(y_rnd);
      end
      if (!tail.side.keep) begin
         x_out = '0;
         y_out = '0;
      end
      rsp_data_in  = RSP_DATA_W'({tail.side.kept, y_out, x_out});
      rsp_valid_in = chain_ready[CORDIC_STAGES] ? chain_valid[CORDIC_STAGES] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= tail.side.keep;
         rsp_last_ff <= tail.side.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> design/rstp_front.sv
module rstp_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [rstp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rstp_pkg::REG_W-1:0]      csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [rstp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tlast,
   output logic                           out_valid,
   input  logic                           out_ready,
   output rstp_pkg::rstp_vec_type          out_vec
);
   import rstp_pkg::*;

   logic [ANGLE_BITS-1:0] start_angle_ff, angle_step_ff, beam_angle_ff, beam_angle_in;
   logic [RANGE_BITS-1:0] usable_range_ff, sensor_max_ff;
   logic [CNT_W-1:0]      kept_count_ff, kept_count_in, cnt_next;
   logic                  valid_ff, valid_in;
   rstp_vec_type          vec_ff, vec_in;

   logic [RANGE_BITS-1:0] range_val, limit;
   logic                  keep, take, fold;
   logic [PROD_W-1:0]     prod;
   logic [XY_W-1:0]       mag;
   logic [TURN_W-1:0]     turn_angle;

   assign req_tready = !valid_ff || out_ready;
   assign take       = req_tvalid && req_tready;
   assign out_valid  = valid_ff;
   assign out_vec    = vec_ff;

   always_comb begin
      range_val  = RANGE_BITS'(req_tdata);
      limit      = (usable_range_ff < sensor_max_ff) ? usable_range_ff : sensor_max_ff;
      keep       = (range_val < limit) && (kept_count_ff < CNT_W'(MAX_BEAMS));
      cnt_next   = kept_count_ff + CNT_W'(keep);
      prod       = PROD_W'(range_val) * PROD_W'(GAIN_Q32);
      mag        = XY_W'(prod[PROD_W-1:TURN_W-GUARD]);
      turn_angle = TURN_W'(beam_angle_ff) << (TURN_W - ANGLE_BITS);
      fold       = turn_angle[TURN_W-1] ^ turn_angle[TURN_W-2];

      vec_in.x         = fold ? -mag : mag;
      vec_in.y         = '0;
      vec_in.z         = fold ? {~turn_angle[TURN_W-1], turn_angle[TURN_W-2:0]} : turn_angle;
      vec_in.side.keep = keep;
      vec_in.side.kept = KEPT_W'(cnt_next);
      vec_in.side.last = req_tlast;

      valid_in      = req_tready ? req_tvalid : valid_ff;
      beam_angle_in = beam_angle_ff;
      kept_count_in = kept_count_ff;
      if (csr_we && (csr_addr == CSR_START_ANGLE)) begin
         beam_angle_in = ANGLE_BITS'(csr_wdata);
      end else if (take) begin
         if (req_tlast) begin
            beam_angle_in = start_angle_ff;
            kept_count_in = '0;
         end else begin
            beam_angle_in = beam_angle_ff + angle_step_ff;
            kept_count_in = cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff  <= '0;
         angle_step_ff   <= '0;
         usable_range_ff <= RANGE_BITS'(16'hFFFF);
         sensor_max_ff   <= RANGE_BITS'(16'hFFFF);
         beam_angle_ff   <= '0;
         kept_count_ff   <= '0;
         valid_ff        <= 1'b0;
      end else begin
         beam_angle_ff <= beam_angle_in;
         kept_count_ff <= kept_count_in;
         valid_ff      <= valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_START_ANGLE:  start_angle_ff  <= ANGLE_BITS'(csr_wdata);
               CSR_ANGLE_STEP:   angle_step_ff   <= ANGLE_BITS'(csr_wdata);
               CSR_USABLE_RANGE: usable_range_ff <= RANGE_BITS'(csr_wdata);
               CSR_SENSOR_MAX:   sensor_max_ff   <= RANGE_BITS'(csr_wdata);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         vec_ff <= vec_in;
      end
   end

endmodule

>>> design/rstp_cordic_cell.sv
module rstp_cordic_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [rstp_pkg::STAGE_W-1:0] stage_idx,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  rstp_pkg::rstp_vec_type        in_vec,
   output logic                         out_valid,
   input  logic                         out_ready,
   output rstp_pkg::rstp_vec_type        out_vec
);
   import rstp_pkg::*;

   logic                   valid_ff, valid_in;
   rstp_vec_type           vec_ff, vec_in;
   logic signed [XY_W-1:0] dx, dy;
   logic [TURN_W-1:0]      atan_val;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

   always_comb begin
      dx       = in_vec.y >>> stage_idx;
      dy       = in_vec.x >>> stage_idx;
      atan_val = ATAN_TABLE[stage_idx];
      vec_in   = in_vec;
      if (!in_vec.z[TURN_W-1]) begin
         vec_in.x = in_vec.x - dx;
         vec_in.y = in_vec.y + dy;
         vec_in.z = in_vec.z - $signed(atan_val);
      end else begin
         vec_in.x = in_vec.x + dx;
         vec_in.y = in_vec.y - dy;
         vec_in.z = in_vec.z + $signed(atan_val);
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         vec_ff <= vec_in;
      end
   end

endmodule

>>> design/rstp_checker.sv
module rstp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rstp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tlast
);
   import rstp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("Stalled result changed.");

   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[2*COORD_W-1:0] == '0)
      else $error("Dropped point carries nonzero coordinates.");

   a_kept_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[2*COORD_W+KEPT_W-1:2*COORD_W] != '0)
      else $error("Kept point reports a zero count.");

   a_saturate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[COORD_W-1:0] != 17'h10000
         && rsp_tdata[2*COORD_W-1:COORD_W] != 17'h10000)
      else $error("Coordinate outside the saturation range.");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("Result present right after reset.");

endmodule

bind range_scan_to_points rstp_checker u_rstp_checker (.*);

>>> test/point_checker.sv
module point_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [rstp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [rstp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tuser,
   input  logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [rstp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [rstp_pkg::REG_W-1:0]      csr_wdata,
   output int                              pending,
   output int                              errors
);
   timeunit 1ns;
   timeprecision 1ps;

   import rstp_pkg::*;

   localparam longint unsigned INV_GAIN = 64'd2608131496;
   localparam logic [31:0] ARCTAN [24] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic                      valid;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [KEPT_W-1:0]         kept;
      logic                      done;
   } point_rec_type;

   point_rec_type     expected_points [$];
   point_rec_type     want;
   point_rec_type     got;
   logic [15:0]       start_angle_q;
   logic [15:0]       angle_step_q;
   logic [15:0]       usable_q;
   logic [15:0]       sensor_q;
   logic [15:0]       beam_angle_q;
   logic [KEPT_W-1:0] kept_q;
   logic [15:0]       range_limit;

   initial begin
      errors = 0;
      pending = 0;
   end

   function automatic logic signed [COORD_W-1:0] saturate_coord(input longint v);
      if (v > COORD_MAX) v = COORD_MAX;
      if (v < -COORD_MAX) v = -COORD_MAX;
      return COORD_W'(v);
   endfunction

   // The start vector is folded by a half turn when the angle lies outside
   // the right half plane, then rotated with floor-rounded shifts.
   function automatic void cordic_rotate(input logic [15:0] rng, input logic [15:0] ang,
                                         output logic signed [COORD_W-1:0] px,
                                         output logic signed [COORD_W-1:0] py);
      logic [31:0] u;
      longint      x;
      longint      y;
      longint      z;
      longint      dx;
      longint      dy;
      int          i;
      u = {ang, 16'h0000};
      x = longint'((64'(rng) * INV_GAIN) >> (32 - GUARD));
      y = 0;
      if (u[31:30] == 2'b01 || u[31:30] == 2'b10) begin
         u = u + 32'h8000_0000;
         x = -x;
      end
      z = longint'($signed(u));
      for (i = 0; i < CORDIC_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(ARCTAN[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(ARCTAN[i]);
         end
      end
      px = saturate_coord((x + (64'sd1 <<< (GUARD - 1))) >>> GUARD);
      py = saturate_coord((y + (64'sd1 <<< (GUARD - 1))) >>> GUARD);
   endfunction

   task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
      $display("ERROR at %0t ns: %s expected %0d, got %0d", $realtime, what, exp_v, got_v);
      errors = errors + 1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start_angle_q = 16'h0000;
         angle_step_q = 16'h0000;
         usable_q = 16'hFFFF;
         sensor_q = 16'hFFFF;
         beam_angle_q = 16'h0000;
         kept_q = '0;
         expected_points.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_START_ANGLE: begin
                  start_angle_q = csr_wdata;
                  beam_angle_q = csr_wdata;
               end
               CSR_ANGLE_STEP: angle_step_q = csr_wdata;
               CSR_USABLE_RANGE: usable_q = csr_wdata;
               CSR_SENSOR_MAX: sensor_q = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               report_mismatch("result with no request pending", 0, 1);
            end else begin
               want = expected_points.pop_front();
               got.valid = rsp_tuser;
               got.x = rsp_tdata[COORD_W-1:0];
               got.y = rsp_tdata[2*COORD_W-1:COORD_W];
               got.kept = rsp_tdata[2*COORD_W+KEPT_W-1:2*COORD_W];
               got.done = rsp_tlast;
               if (got.valid !== want.valid)
                  report_mismatch("point_valid", want.valid, got.valid);
               if (got.x !== want.x)
                  report_mismatch("point_x", want.x, got.x);
               if (got.y !== want.y)
                  report_mismatch("point_y", want.y, got.y);
               if (got.kept !== want.kept)
                  report_mismatch("points_kept", want.kept, got.kept);
               if (got.done !== want.done)
                  report_mismatch("scan_done", want.done, got.done);
               if (rsp_tdata[RSP_DATA_W-1:2*COORD_W+KEPT_W] !== '0)
                  report_mismatch("tdata fill bits", 0,
                                  rsp_tdata[RSP_DATA_W-1:2*COORD_W+KEPT_W]);
            end
         end
         if (req_tvalid && req_tready) begin
            range_limit = (usable_q < sensor_q) ? usable_q : sensor_q;
            want.valid = (req_tdata < range_limit) && (kept_q < MAX_BEAMS);
            want.x = '0;
            want.y = '0;
            if (want.valid) begin
               cordic_rotate(req_tdata, beam_angle_q, want.x, want.y);
               kept_q = kept_q + 1'b1;
            end
            want.kept = kept_q;
            want.done = req_tlast;
            expected_points.push_back(want);
            if (req_tlast) begin
               kept_q = '0;
               beam_angle_q = start_angle_q;
            end else begin
               beam_angle_q = beam_angle_q + angle_step_q;
            end
         end
      end
      pending = expected_points.size();
   end

endmodule

>>> test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rstp_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int LONG_SCAN    = 1040;
   localparam int DRAIN_CYCLES = CORDIC_STAGES + 6;
   localparam int PHASE_ITEMS  = 60;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr = CSR_START_ANGLE;
   logic [REG_W-1:0]        csr_wdata = '0;
   int                      pending;
   int                      errors;
   int                      cycles = 0;
   int                      mode = 0;
   logic                    pressure = 1'b0;
   int                      hold_cycles = 0;
   logic [15:0]             scan_limit = 16'hFFFF;

   range_scan_to_points DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   point_checker point_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .errors     (errors)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // The long hold-off lets the pipeline fill so that the request side stalls.
   always @(negedge clock) begin
      if (pressure && hold_cycles < HOLD_CYCLES) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles + 1;
      end else if (mode == 2) begin
         rsp_tready <= ($urandom_range(99) >= 76);
      end else if (mode == 3) begin
         rsp_tready <= ($urandom_range(99) >= 26);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_beam(input logic [15:0] beam, input logic last);
      int pct;
      pct = (mode == 1) ? 76 : (mode == 3) ? 26 : 0;
      while ($urandom_range(99) < pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= beam;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_regs(input logic [15:0] start_v, input logic [15:0] step_v,
                             input logic [15:0] usable_v, input logic [15:0] sensor_v);
      csr_we <= 1'b1;
      csr_addr <= CSR_START_ANGLE;
      csr_wdata <= start_v;
      @(negedge clock);
      csr_addr <= CSR_ANGLE_STEP;
      csr_wdata <= step_v;
      @(negedge clock);
      csr_addr <= CSR_USABLE_RANGE;
      csr_wdata <= usable_v;
      @(negedge clock);
      csr_addr <= CSR_SENSOR_MAX;
      csr_wdata <= sensor_v;
      @(negedge clock);
      csr_we <= 1'b0;
      scan_limit = (usable_v < sensor_v) ? usable_v : sensor_v;
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Most ranges lie below the limit, with a share drawn from the full field.
   function automatic logic [15:0] pick_range(input logic [15:0] lim);
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 70 && lim > 0) return 16'($urandom_range(int'(lim) - 1));
      if (sel < 76) return lim;
      if (sel < 82 && lim > 0) return lim - 16'd1;
      if (sel < 85) return 16'h0000;
      if (sel < 88) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   task automatic run_scans(input int total);
      int   sent;
      int   len;
      int   j;
      logic last;
      sent = 0;
      while (sent < total) begin
         len = $urandom_range(1, 40);
         for (j = 0; j < len && sent < total; j++) begin
            last = (j == len - 1) || ($urandom_range(99) < 3);
            send_beam(pick_range(scan_limit), last);
            sent++;
         end
      end
   endtask

   initial begin
      int phase;
      int j;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      send_beam(16'h0000, 1'b0);
      send_beam(16'hFFFF, 1'b0);
      send_beam(16'hFFFE, 1'b0);
      send_beam(16'h0001, 1'b1);
      wait_for_drain();

      // An eighth-turn step from the half turn visits every octant boundary.
      write_regs(16'h8000, 16'h2000, 16'hFFFF, 16'hFFFF);
      for (j = 0; j < 8; j++) send_beam(16'hFFFE, 1'b0);
      send_beam(16'h0001, 1'b1);
      wait_for_drain();
      write_regs(16'h4000, 16'h8000, 16'hFFFF, 16'hFFFF);
      for (j = 0; j < 4; j++) send_beam(16'hFFFE, j == 3);

      for (phase = 1; phase <= 7; phase++) begin
         wait_for_drain();
         mode = phase % 4;
         case (phase)
            1: write_regs(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
            2: write_regs(16'($urandom), 16'($urandom), 16'h0000, 16'hFFFF);
            3: write_regs(16'($urandom), 16'($urandom), 16'hFFFF, 16'h0000);
            4: write_regs(16'h0000, 16'h4000, 16'hFFFF, 16'hFFFF);
            5: write_regs(16'($urandom), 16'h0001, 16'($urandom), 16'($urandom));
            6: write_regs(16'($urandom), 16'hFFFF, 16'h8000, 16'hFFFF);
            default: write_regs(16'h8000, 16'h7FFF, 16'($urandom), 16'd40000);
         endcase
         if (phase == 4) begin
            // One scan longer than the point list, so the list runs full.
            pressure = 1'b1;
            for (j = 0; j < LONG_SCAN; j++)
               send_beam(16'($urandom_range(65534)), j == LONG_SCAN - 1);
         end else begin
            run_scans(PHASE_ITEMS);
         end
      end

      wait_for_drain();
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
design/rstp_pkg.sv
design/rstp_front.sv
design/rstp_cordic_cell.sv
design/range_scan_to_points.sv
design/rstp_checker.sv
test/point_checker.sv
test/testbench.sv
